FILE: rtl/dq_pkg.sv
// Shared types, codes and ring helper for the double-ended queue.
// No dependencies; every other file but dq_ram imports this package.
package dq_pkg;

  localparam int DEPTH   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int ENT_W   = 6;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP_FWD   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP_BWD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } dq_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] item;
    logic [ENT_W-1:0]         entries;
    logic                     last;
  } dq_res_t;

  // controller -> datapath
  typedef struct packed {
    logic push;
    logic pop;
    logic dump_start;
    logic dump_next;
    logic at_front;   // front side for push/pop, forward order for dump
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic multi;      // more than one entry held
    logic step_last;  // current dump index is the final entry
  } dq_stat_t;

  // (front + off) mod DEPTH, both operands below DEPTH
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, front} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/dq_ram.sv
// Generic single-port RAM with registered read data.
// No package dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dq_ctrl.sv
// Controller: accepts items, decodes the mode, sequences dumps.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [MODE_W-1:0] mode_i,
  input  dq_stat_t          stat_i,
  output dq_cmd_t           cmd_o,
  output logic              busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state_q, state_d;
  logic dir_q, dir_d;
  logic accept;
  logic is_push, is_pop, is_dump, front_side;

  assign busy   = (state_q == S_DUMP);
  assign accept = start & ~busy;

  assign is_push    = (mode_i == MODE_PUSH_FRONT) || (mode_i == MODE_PUSH_BACK);
  assign is_pop     = (mode_i == MODE_POP_FRONT) || (mode_i == MODE_POP_BACK);
  assign is_dump    = (mode_i == MODE_DUMP_FWD) || (mode_i == MODE_DUMP_BWD);
  assign front_side = (mode_i == MODE_PUSH_FRONT) || (mode_i == MODE_POP_FRONT) ||
                      (mode_i == MODE_DUMP_FWD);

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.push       = accept & is_push;
        cmd_o.pop        = accept & is_pop;
        cmd_o.dump_start = accept & is_dump;
        cmd_o.at_front   = front_side;
        if (accept && is_dump && !stat_i.empty && stat_i.multi) begin
          state_d = S_DUMP;
          dir_d   = front_side;
        end
      end
      S_DUMP: begin
        cmd_o.dump_next = 1'b1;
        cmd_o.at_front  = dir_q;
        if (stat_i.step_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

endmodule

FILE: rtl/dq_dpath.sv
// Datapath: ring pointers, entry count, dump index, slot RAM, result register.
// Depends on dq_pkg and dq_ram.
module dq_dpath
  import dq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dq_cmd_t             cmd_i,
  input  logic [DATA_W-1:0]   value_i,
  output dq_stat_t            stat_o,
  output logic                res_valid_o,
  output dq_res_t             res_o
);

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic             from_ram_q, from_ram_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ENT_W-1:0]  entries_q, entries_d;
  logic              last_q, last_d;

  logic             full, empty;
  logic [CNT_W-1:0] cnt_m1, k, dump_off;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign cnt_m1 = count_q - 1'b1;
  assign k      = cmd_i.dump_start ? '0 : idx_q;
  assign dump_off = cmd_i.at_front ? k : (cnt_m1 - k);

  assign stat_o.empty     = empty;
  assign stat_o.multi     = (count_q > CNT_W'(1));
  assign stat_o.step_last = (idx_q == cnt_m1);

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    idx_d      = idx_q;
    valid_d    = 1'b0;
    from_ram_d = 1'b0;
    status_d   = STAT_OK;
    entries_d  = ENT_W'(count_q);
    last_d     = 1'b1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = front_q;
    if (cmd_i.push) begin
      valid_d = 1'b1;
      if (full) begin
        status_d = STAT_FULL;
      end else begin
        ram_we  = 1'b1;
        count_d = count_q + 1'b1;
        if (cmd_i.at_front) begin
          front_d  = ring_pos(front_q, IDX_W'(DEPTH - 1));
          ram_addr = front_d;
        end else begin
          ram_addr = ring_pos(front_q, count_q[IDX_W-1:0]);
        end
        entries_d = ENT_W'(count_d);
      end
    end else if (cmd_i.pop) begin
      valid_d = 1'b1;
      if (empty) begin
        status_d = STAT_EMPTY;
      end else begin
        ram_re     = 1'b1;
        from_ram_d = 1'b1;
        count_d    = cnt_m1;
        if (cmd_i.at_front) begin
          ram_addr = front_q;
          front_d  = ring_pos(front_q, IDX_W'(1));
        end else begin
          ram_addr = ring_pos(front_q, cnt_m1[IDX_W-1:0]);
        end
        entries_d = ENT_W'(count_d);
      end
    end else if (cmd_i.dump_start || cmd_i.dump_next) begin
      valid_d = 1'b1;
      if (empty) begin
        status_d = STAT_EMPTY;
      end else begin
        ram_re     = 1'b1;
        from_ram_d = 1'b1;
        ram_addr   = ring_pos(front_q, dump_off[IDX_W-1:0]);
        idx_d      = k + 1'b1;
        last_d     = (k == cnt_m1);
      end
    end
  end

  dq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(value_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_ram_q <= from_ram_d;
    status_q   <= status_d;
    entries_q  <= entries_d;
    last_q     <= last_d;
  end

  // item comes straight off the RAM read register in the result cycle
  assign res_valid_o    = valid_q;
  assign res_o.status   = status_q;
  assign res_o.item     = from_ram_q ? ram_rdata : '0;
  assign res_o.entries  = entries_q;
  assign res_o.last     = last_q;

endmodule

FILE: rtl/double_ended_queue.sv
// Double-ended queue of 32-bit values in a DEPTH-slot ring RAM.
// Push and pop: back-to-back items accepted, result strobed the cycle after accept.
// Dump of n entries: n results, busy held after accept until the final entry is read;
// the single slot RAM port reads one entry per cycle.
// Reset clears the pointers and count; the queue starts empty, no clearing pass.
// Results cannot be stalled by the receiver. Depends on dq_pkg, dq_ctrl, dq_dpath.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  dq_req_t req_i,
  output logic    busy,
  output logic    res_valid_o,
  output dq_res_t res_o
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .mode_i(req_i.mode),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy  (busy)
  );

  dq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (req_i.value),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for double_ended_queue: directed and random pushes, pops, dumps.
// Depends on dq_pkg and the double_ended_queue RTL. Expected results come from a shadow ring
// kept here.
module testbench;
  import dq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 370;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  dq_req_t req_i;
  logic    busy;
  logic    res_valid_o;
  dq_res_t res_o;

  double_ended_queue i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // shadow copy of the ring
  logic signed [DATA_W-1:0] shadow_slot [DEPTH];
  int shadow_head;
  int shadow_count;

  dq_res_t pending_results[$];

  int errors;
  int items_sent;
  int results_seen;
  int dumps_sent;
  int full_drops;
  int empty_reports;
  int max_fill;
  int burst_left;
  int idle_cycles;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void queue_result(input logic [STAT_W-1:0] status,
                                       input logic signed [DATA_W-1:0] item,
                                       input logic last);
    dq_res_t r;
    r.status  = status;
    r.item    = item;
    r.entries = ENT_W'(shadow_count);
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  // Advance the shadow ring by one accepted item and queue the results it causes.
  function automatic void deque_apply(input dq_req_t rq);
    int off;
    logic signed [DATA_W-1:0] v;
    case (rq.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          full_drops++;
          queue_result(STAT_FULL, '0, 1'b1);
        end else begin
          if (rq.mode == MODE_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_slot[shadow_head] = rq.value;
          end else begin
            shadow_slot[(shadow_head + shadow_count) % DEPTH] = rq.value;
          end
          shadow_count++;
          if (shadow_count > max_fill) max_fill = shadow_count;
          queue_result(STAT_OK, '0, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (shadow_count == 0) begin
          empty_reports++;
          queue_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          if (rq.mode == MODE_POP_FRONT) begin
            v = shadow_slot[shadow_head];
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            v = shadow_slot[(shadow_head + shadow_count - 1) % DEPTH];
          end
          shadow_count--;
          queue_result(STAT_OK, v, 1'b1);
        end
      end
      MODE_DUMP_FWD, MODE_DUMP_BWD: begin
        dumps_sent++;
        if (shadow_count == 0) begin
          empty_reports++;
          queue_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            off = (rq.mode == MODE_DUMP_FWD) ? i : shadow_count - 1 - i;
            queue_result(STAT_OK, shadow_slot[(shadow_head + off) % DEPTH],
                         i + 1 == shadow_count);
          end
        end
      end
      default: ;  // spare codes: ignored, no result
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // start is left high so back-to-back items need no extra edge.
  task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
    dq_req_t rq;
    rq.mode  = m;
    rq.value = v;
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    deque_apply(rq);
    items_sent++;
    @(negedge clk_i);
  endtask

  // send one item, then maybe close the burst with a gap
  task automatic issue(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
    send_op(m, v);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      // every so often a long burst with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] side_pick(input logic [MODE_W-1:0] a,
                                                  input logic [MODE_W-1:0] b);
    return $urandom_range(0, 1) ? a : b;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    dq_res_t want;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d item %h entries %0d",
                 $time, res_o.status, res_o.item, res_o.entries);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(res_o.status));
        check_field("item", want.item, res_o.item);
        check_field("entries", DATA_W'(want.entries), DATA_W'(res_o.entries));
        check_field("last", DATA_W'(want.last), DATA_W'(res_o.last));
      end
    end
  end

  // watchdog: counts cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no activity for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_results.size());
        $display("double_ended_queue regression: fail");
        $finish;
      end
    end
  end

  task automatic test_empty_queue();
    issue(MODE_POP_FRONT, rand_value());
    issue(MODE_POP_BACK, rand_value());
    issue(MODE_DUMP_FWD, rand_value());
    issue(MODE_DUMP_BWD, rand_value());
    issue(MODE_SPARE_A, rand_value());
    issue(MODE_SPARE_B, rand_value());
    issue(MODE_POP_FRONT, '0);
  endtask

  task automatic test_value_extremes();
    issue(MODE_PUSH_FRONT, 32'sh8000_0000);
    issue(MODE_PUSH_BACK, 32'sh7fff_ffff);
    issue(MODE_PUSH_FRONT, '1);
    issue(MODE_PUSH_BACK, '0);
    issue(MODE_SPARE_B, 32'sh5555_aaaa);
    issue(MODE_DUMP_FWD, '0);
    issue(MODE_DUMP_BWD, '1);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_POP_BACK, '0);
    issue(MODE_POP_BACK, '0);
    issue(MODE_DUMP_FWD, '0);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_POP_FRONT, '0);  // empty again
  endtask

  // fill to the brim, overflow from both ends, dump the full ring, then drain
  task automatic test_full_queue();
    while (shadow_count > 0) issue(side_pick(MODE_POP_FRONT, MODE_POP_BACK), '0);
    while (shadow_count < DEPTH) issue(side_pick(MODE_PUSH_FRONT, MODE_PUSH_BACK),
                                       rand_value());
    issue(MODE_PUSH_FRONT, rand_value());
    issue(MODE_PUSH_BACK, rand_value());
    issue(MODE_DUMP_FWD, '0);
    issue(MODE_DUMP_BWD, '0);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_PUSH_FRONT, rand_value());
    issue(MODE_PUSH_BACK, rand_value());
    while (shadow_count > 0) issue(side_pick(MODE_POP_FRONT, MODE_POP_BACK), '0);
    issue(MODE_POP_BACK, '0);
  endtask

  // segments with a push-heavy, pop-heavy or even bias
  task automatic test_random_mix();
    int counted;
    int seg_len;
    int push_pct;
    int r;
    logic [MODE_W-1:0] m;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 45);
      case ($urandom_range(0, 2))
        0: push_pct = 70;
        1: push_pct = 25;
        default: push_pct = 45;
      endcase
      // now and then let every result land before going on
      if ($urandom_range(0, 7) == 0) wait_drained();
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        if (r < 2) m = side_pick(MODE_SPARE_A, MODE_SPARE_B);
        else if (r < 10) m = side_pick(MODE_DUMP_FWD, MODE_DUMP_BWD);
        else if (r < 10 + push_pct) m = side_pick(MODE_PUSH_FRONT, MODE_PUSH_BACK);
        else m = side_pick(MODE_POP_FRONT, MODE_POP_BACK);
        issue(m, rand_value());
        if (m != MODE_SPARE_A && m != MODE_SPARE_B) counted++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    dumps_sent   = 0;
    full_drops   = 0;
    empty_reports = 0;
    max_fill     = 0;
    idle_cycles  = 0;
    shadow_head  = 0;
    shadow_count = 0;
    burst_left   = $urandom_range(1, 10);
    // count rising edges so the first clock transition cannot shorten reset
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_value_extremes();
    wait_drained();
    test_full_queue();
    test_random_mix();

    wait_drained();
    repeat (DEPTH + 8) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Covered %0d items, %0d results checked, %0d dumps, %0d dropped pushes,",
             items_sent, results_seen, dumps_sent, full_drops);
    $display("%0d empty reports, peak fill %0d of %0d; %0d errors.",
             empty_reports, max_fill, DEPTH, errors);
    if (errors == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/dq_dpath.sv
rtl/double_ended_queue.sv
sim/testbench.sv
